[rtl/core/pidsc_pkg.sv]
`timescale 1ns / 1ps

package pidsc_pkg;

  // fixed-point widths
  localparam int IN_W    = 20;            // Q10.10 input samples
  localparam int OUT_W   = 20;            // Q10.10 drive value
  localparam int ERR_W   = 21;            // target - measured
  localparam int DIFF_W  = 22;            // error - last error
  localparam int INTEG_W = 21;            // integral state
  localparam int DERIV_W = 31;            // rounded derivative
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 19;
  localparam int MA_W    = 31;            // multiplier operand A (signed)
  localparam int MB_W    = 17;            // multiplier operand B (signed)
  localparam int PROD_W  = MA_W + MB_W;   // 48
  localparam int ACC_W   = PROD_W + 1;    // 49, sum of four products
  localparam int RND_W   = ACC_W - 8;     // rounded sum
  localparam int ISH_W   = PROD_W - 16;   // integral sum after shift

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // register indexes
  localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [2:0] REG_FF_GAIN    = 3'd3;
  localparam logic [2:0] REG_INTEG_LIM  = 3'd4;
  localparam logic [2:0] REG_OUT_LIM    = 3'd5;
  localparam logic [2:0] REG_TIME_STEP  = 3'd6;
  localparam logic [2:0] REG_INV_STEP   = 3'd7;

  // reset values
  localparam logic [LIM_W-1:0]  RST_INTEG_LIM = 19'd10240;
  localparam logic [LIM_W-1:0]  RST_OUT_LIM   = 19'd409600;
  localparam logic [GAIN_W-1:0] RST_TIME_STEP = 16'd1966;
  localparam logic [GAIN_W-1:0] RST_INV_STEP  = 16'd8533;

  // item commands
  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  // multiplier operand selects
  localparam logic [2:0] MS_FF     = 3'd0;  // ff_gain * target
  localparam logic [2:0] MS_ISTEP  = 3'd1;  // error * time_step
  localparam logic [2:0] MS_DSTEP  = 3'd2;  // (error - last) * inv_time_step
  localparam logic [2:0] MS_PROP   = 3'd3;  // prop_gain * error
  localparam logic [2:0] MS_INTEG  = 3'd4;  // integ_gain * integral
  localparam logic [2:0] MS_DERIV  = 3'd5;  // deriv_gain * derivative

  // rounding constants
  localparam logic signed [PROD_W-1:0] PROD_RND16 = 48'sd32768;
  localparam logic signed [PROD_W-1:0] PROD_RND8  = 48'sd128;
  localparam logic signed [ACC_W-1:0]  ACC_RND8   = 49'sd128;

  typedef struct packed {
    logic                     cmd;
    logic signed [IN_W-1:0]   target_value;
    logic signed [IN_W-1:0]   measured_value;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]  control_output;
    logic                     output_saturated;
  } result_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic signed [GAIN_W-1:0] ff_gain;
    logic [LIM_W-1:0]         integ_limit;
    logic [LIM_W-1:0]         drive_limit;
    logic [GAIN_W-1:0]        time_step;
    logic [GAIN_W-1:0]        inv_time_step;
  } cfg_t;

  typedef struct packed {
    logic       load;         // latch error terms from the accepted word
    logic       clear;        // zero integral and last error
    logic [2:0] mul_sel;
    logic       acc_init;
    logic       acc_add;
    logic       integ_upd;
    logic       deriv_upd;
    logic       finish;
    logic       finish_zero;
  } dp_cmd_t;

endpackage

[rtl/core/pidsc_regs.sv]
`timescale 1ns / 1ps

module pidsc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pidsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pidsc_pkg::DATA_W-1:0]   pwdata,
  output logic [pidsc_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output pidsc_pkg::cfg_t                cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= '0;
      cfg.integ_gain    <= '0;
      cfg.deriv_gain    <= '0;
      cfg.ff_gain       <= '0;
      cfg.integ_limit   <= pidsc_pkg::RST_INTEG_LIM;
      cfg.drive_limit   <= pidsc_pkg::RST_OUT_LIM;
      cfg.time_step     <= pidsc_pkg::RST_TIME_STEP;
      cfg.inv_time_step <= pidsc_pkg::RST_INV_STEP;
    end else if (wr) begin
      unique case (idx)
        pidsc_pkg::REG_PROP_GAIN:  cfg.prop_gain     <= pwdata[15:0];
        pidsc_pkg::REG_INTEG_GAIN: cfg.integ_gain    <= pwdata[15:0];
        pidsc_pkg::REG_DERIV_GAIN: cfg.deriv_gain    <= pwdata[15:0];
        pidsc_pkg::REG_FF_GAIN:    cfg.ff_gain       <= $signed(pwdata[15:0]);
        pidsc_pkg::REG_INTEG_LIM:  cfg.integ_limit   <= pwdata[18:0];
        pidsc_pkg::REG_OUT_LIM:    cfg.drive_limit   <= pwdata[18:0];
        pidsc_pkg::REG_TIME_STEP:  cfg.time_step     <= pwdata[15:0];
        pidsc_pkg::REG_INV_STEP:   cfg.inv_time_step <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pidsc_pkg::REG_PROP_GAIN:  prdata = {16'b0, cfg.prop_gain};
      pidsc_pkg::REG_INTEG_GAIN: prdata = {16'b0, cfg.integ_gain};
      pidsc_pkg::REG_DERIV_GAIN: prdata = {16'b0, cfg.deriv_gain};
      pidsc_pkg::REG_FF_GAIN:    prdata = {16'b0, cfg.ff_gain};
      pidsc_pkg::REG_INTEG_LIM:  prdata = {13'b0, cfg.integ_limit};
      pidsc_pkg::REG_OUT_LIM:    prdata = {13'b0, cfg.drive_limit};
      pidsc_pkg::REG_TIME_STEP:  prdata = {16'b0, cfg.time_step};
      pidsc_pkg::REG_INV_STEP:   prdata = {16'b0, cfg.inv_time_step};
      default:                   prdata = '0;
    endcase
  end

endmodule

[rtl/core/pidsc_dp.sv]
`timescale 1ns / 1ps

module pidsc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pidsc_pkg::cfg_t      cfg,
  input  pidsc_pkg::sample_t   sample,
  input  pidsc_pkg::dp_cmd_t   dp_cmd,
  output pidsc_pkg::result_t   result
);

  logic signed [pidsc_pkg::ERR_W-1:0]   err_c, err, last_err;
  logic signed [pidsc_pkg::DIFF_W-1:0]  diff_c, diff;
  logic signed [pidsc_pkg::INTEG_W-1:0] integ;
  logic signed [pidsc_pkg::DERIV_W-1:0] deriv;
  logic signed [pidsc_pkg::MA_W-1:0]    op_a;
  logic signed [pidsc_pkg::MB_W-1:0]    op_b;
  logic signed [pidsc_pkg::PROD_W-1:0]  prod;
  logic signed [pidsc_pkg::ACC_W-1:0]   acc;

  logic signed [pidsc_pkg::PROD_W-1:0]  isum, dsum;
  logic signed [pidsc_pkg::ISH_W-1:0]   ishift, ilim_s, iclamp;
  logic signed [pidsc_pkg::RND_W-1:0]   rnd, olim_s, oclamp;
  logic                                 sat_hi, sat_lo;

  assign err_c  = pidsc_pkg::ERR_W'(sample.target_value)
                - pidsc_pkg::ERR_W'(sample.measured_value);
  assign diff_c = pidsc_pkg::DIFF_W'(err_c) - pidsc_pkg::DIFF_W'(last_err);

  // shared multiplier operand select
  always_comb begin
    case (dp_cmd.mul_sel)
      pidsc_pkg::MS_FF: begin
        op_a = pidsc_pkg::MA_W'(sample.target_value);
        op_b = pidsc_pkg::MB_W'(cfg.ff_gain);
      end
      pidsc_pkg::MS_ISTEP: begin
        op_a = pidsc_pkg::MA_W'(err);
        op_b = $signed({1'b0, cfg.time_step});
      end
      pidsc_pkg::MS_DSTEP: begin
        op_a = pidsc_pkg::MA_W'(diff);
        op_b = $signed({1'b0, cfg.inv_time_step});
      end
      pidsc_pkg::MS_PROP: begin
        op_a = pidsc_pkg::MA_W'(err);
        op_b = $signed({1'b0, cfg.prop_gain});
      end
      pidsc_pkg::MS_INTEG: begin
        op_a = pidsc_pkg::MA_W'(integ);
        op_b = $signed({1'b0, cfg.integ_gain});
      end
      pidsc_pkg::MS_DERIV: begin
        op_a = deriv;
        op_b = $signed({1'b0, cfg.deriv_gain});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // integral: round error*step to Q10.10 and add in one pass, then clamp
  assign isum   = prod + (pidsc_pkg::PROD_W'(integ) <<< 16) + pidsc_pkg::PROD_RND16;
  assign ishift = $signed(isum[pidsc_pkg::PROD_W-1:16]);
  assign ilim_s = $signed(pidsc_pkg::ISH_W'(cfg.integ_limit));
  assign iclamp = (ishift > ilim_s) ? ilim_s :
                  (ishift < -ilim_s) ? -ilim_s : ishift;

  assign dsum   = prod + pidsc_pkg::PROD_RND8;

  // acc already carries the rounding offset
  assign rnd    = $signed(acc[pidsc_pkg::ACC_W-1:8]);
  assign olim_s = $signed(pidsc_pkg::RND_W'(cfg.drive_limit));
  assign sat_hi = rnd > olim_s;
  assign sat_lo = rnd < -olim_s;
  assign oclamp = sat_hi ? olim_s : (sat_lo ? -olim_s : rnd);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (dp_cmd.load) begin
      err  <= err_c;
      diff <= diff_c;
    end
    if (dp_cmd.deriv_upd) begin
      deriv <= $signed(dsum[pidsc_pkg::DERIV_W+7:8]);
    end
    if (dp_cmd.acc_init) begin
      acc <= pidsc_pkg::ACC_W'(prod) + pidsc_pkg::ACC_RND8;
    end else if (dp_cmd.acc_add) begin
      acc <= acc + pidsc_pkg::ACC_W'(prod);
    end
    if (dp_cmd.finish) begin
      result.control_output   <= oclamp[pidsc_pkg::OUT_W-1:0];
      result.output_saturated <= sat_hi || sat_lo;
    end else if (dp_cmd.finish_zero) begin
      result <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      last_err <= '0;
    end else if (dp_cmd.clear) begin
      integ    <= '0;
      last_err <= '0;
    end else begin
      if (dp_cmd.load) begin
        last_err <= err_c;
      end
      if (dp_cmd.integ_upd) begin
        integ <= iclamp[pidsc_pkg::INTEG_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_integ_in_limit: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.integ_upd |=> (pidsc_pkg::ISH_W'(integ) <= ilim_s &&
                          pidsc_pkg::ISH_W'(integ) >= -ilim_s))
    else $error("integral outside its clamp");

  a_out_in_limit: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.finish |=> (pidsc_pkg::RND_W'(result.control_output) <= olim_s &&
                       pidsc_pkg::RND_W'(result.control_output) >= -olim_s))
    else $error("drive value outside output clamp");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.clear |=> (integ == '0 && last_err == '0))
    else $error("clear left state nonzero");
`endif

endmodule

[rtl/core/pidsc_ctrl.sv]
`timescale 1ns / 1ps

module pidsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  input  logic                 sample_cmd,
  output logic                 sample_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  output pidsc_pkg::dp_cmd_t   dp_cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ACC0  = 4'd1;  // ff product into acc
  localparam logic [3:0] ST_INTEG = 4'd2;  // integral update
  localparam logic [3:0] ST_DERIV = 4'd3;  // derivative update
  localparam logic [3:0] ST_ADDP  = 4'd4;
  localparam logic [3:0] ST_ADDK  = 4'd5;
  localparam logic [3:0] ST_ADDD  = 4'd6;
  localparam logic [3:0] ST_FIN   = 4'd7;
  localparam logic [3:0] ST_CLR   = 4'd8;

  logic [3:0] state, state_next;
  logic       out_free;

  assign sample_ready = (state == ST_IDLE);
  assign out_free     = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    dp_cmd.mul_sel = pidsc_pkg::MS_FF;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          if (sample_cmd == pidsc_pkg::CMD_CLEAR) begin
            dp_cmd.clear = 1'b1;
            state_next   = ST_CLR;
          end else begin
            dp_cmd.load  = 1'b1;
            state_next   = ST_ACC0;
          end
        end
      end
      ST_ACC0: begin
        dp_cmd.mul_sel  = pidsc_pkg::MS_ISTEP;
        dp_cmd.acc_init = 1'b1;
        state_next      = ST_INTEG;
      end
      ST_INTEG: begin
        dp_cmd.mul_sel   = pidsc_pkg::MS_DSTEP;
        dp_cmd.integ_upd = 1'b1;
        state_next       = ST_DERIV;
      end
      ST_DERIV: begin
        dp_cmd.mul_sel   = pidsc_pkg::MS_PROP;
        dp_cmd.deriv_upd = 1'b1;
        state_next       = ST_ADDP;
      end
      ST_ADDP: begin
        dp_cmd.mul_sel = pidsc_pkg::MS_INTEG;
        dp_cmd.acc_add = 1'b1;
        state_next     = ST_ADDK;
      end
      ST_ADDK: begin
        dp_cmd.mul_sel = pidsc_pkg::MS_DERIV;
        dp_cmd.acc_add = 1'b1;
        state_next     = ST_ADDD;
      end
      ST_ADDD: begin
        dp_cmd.acc_add = 1'b1;
        state_next     = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          dp_cmd.finish = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (out_free) begin
          dp_cmd.finish_zero = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dp_cmd.finish || dp_cmd.finish_zero) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready && sample_cmd == pidsc_pkg::CMD_COMPUTE)
      |=> (state == ST_ACC0))
    else $error("compute word did not start the sequence");

  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && result_valid && !result_ready)
      |=> (state == ST_FIN && result_valid))
    else $error("result overwritten while stalled");

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result word dropped before it was taken");
`endif

endmodule

[rtl/core/pid_step_with_clamps_unit.sv]
`timescale 1ns / 1ps
// PID control step with integral clamp, output clamp and setpoint feedforward.
// sample channel (valid/ready): cmd, target_value, measured_value (Q10.10).
//   cmd compute runs one control step; cmd clear zeroes the integral and the
//   last error and returns a zero word.
// result channel (valid/ready): control_output (Q10.10, clamped to
//   +-drive_limit) and output_saturated.
// APB port: eight 32-bit registers at byte offsets 0x00..0x1C (gains,
//   limits, time step and its reciprocal). pready is always high. Write only
//   while no word is in flight.
// Schedule: one 17x31 multiplier is shared over six products. A compute word
//   steps through ACC0, INTEG, DERIV, ADDP, ADDK, ADDD and FIN, where the
//   result is registered, before the next word is accepted. A clear word
//   steps through CLR, where its zero result is registered.
// The result sits in an output register: if the receiver stalls, the block
//   still takes the next word and runs it up to the final step, then holds
//   there until the waiting result is taken.
// Reset (rst, synchronous): registers go to their reset values, integral and
//   last error to zero, no result pending.

module pid_step_with_clamps_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  pidsc_pkg::sample_t             sample,
  output logic                           result_valid,
  input  logic                           result_ready,
  output pidsc_pkg::result_t             result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pidsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pidsc_pkg::DATA_W-1:0]   pwdata,
  output logic [pidsc_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);

  pidsc_pkg::cfg_t    cfg;
  pidsc_pkg::dp_cmd_t dp_cmd;

  pidsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidsc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_cmd   (sample.cmd),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .dp_cmd       (dp_cmd)
  );

  pidsc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .sample (sample),
    .dp_cmd (dp_cmd),
    .result (result)
  );

endmodule
